FILE: hw/rtl/ppve_pkg.sv
// ----------------------------------------------------------------------------
// ppve_pkg
// Shared types and fixed widths for the prism volume and extent block.
// ----------------------------------------------------------------------------
package ppve_pkg;

  // Fixed field widths
  localparam int HD_BITS   = 19;   // half depth register, z_max
  localparam int ZMIN_BITS = 20;   // negated half depth
  localparam int VOL_BITS  = 63;   // saturated volume
  localparam int SUM_GUARD = 11;   // extra bits of the shoelace sum over 2*coord

  // Bit places of the result flags in the master-side tuser
  localparam int USER_SAT  = 0;
  localparam int USER_INC  = 1;
  localparam int USER_BITS = 2;

  // Classification of one queue entry, made by the front
  typedef struct packed {
    logic keep;    // vertex is held and enters the sums
    logic first;   // first vertex of the polygon
    logic last;    // polygon closes with this entry
    logic few;     // polygon has fewer than three held vertices
  } ppve_kind_t;

  localparam int KIND_BITS = $bits(ppve_kind_t);

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ACC,
    B_CLOSE,
    B_CSUM,
    B_VMUL,
    B_VSUM,
    B_FIN
  } ppve_state_t;

endpackage

FILE: hw/rtl/polygon_prism_volume_extent.sv
// ----------------------------------------------------------------------------
// polygon_prism_volume_extent
// Prism volume (doubled shoelace area times half depth) and 3-D bounding box
// of a polygon streamed one vertex per transfer.
// ----------------------------------------------------------------------------
// A front stage takes one vertex per cycle while the four-entry queue has
// room and classifies it; the back sequencer takes each held vertex through
// a multiply state for the two cross products and an accumulate state that
// updates the box. Closing a polygon runs the closing products, magnitude,
// split volume multiply, partial-product sum and result load in turn; a
// polygon with fewer than three vertices goes from the closing products
// straight to the result load. Vertices past MAX_VERTICES are dropped; a
// marked dropped vertex still closes the polygon. The result waits in an
// output register, so the front keeps taking vertices until the queue fills.
module polygon_prism_volume_extent #(
  parameter int COORD_BITS   = 20,
  parameter int MAX_VERTICES = 1024
) (
  input  logic clk,
  input  logic rst,
  // Configuration: half_depth
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppve_pkg::HD_BITS-1:0]  cfg_data,
  // Vertex stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // x_coord, y_coord, zero fill
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,     // last_vertex
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // prism_volume, x_min, x_max, y_min, y_max, z_min, z_max, zero fill
  output logic [((ppve_pkg::VOL_BITS+4*COORD_BITS+ppve_pkg::ZMIN_BITS
                  +ppve_pkg::HD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // volume_saturated, incomplete
  output logic [ppve_pkg::USER_BITS-1:0] m_axis_tuser
);

  localparam int CB     = COORD_BITS;
  localparam int QW     = 2 * CB + ppve_pkg::KIND_BITS;
  localparam int FLD_W  = ppve_pkg::VOL_BITS + 4 * CB + ppve_pkg::ZMIN_BITS
                          + ppve_pkg::HD_BITS;
  localparam int OUT_W  = ((FLD_W + 7) / 8) * 8;

  logic [ppve_pkg::HD_BITS-1:0]   half_depth;
  logic                           push;
  logic [QW-1:0]                  push_data;
  logic                           queue_full;
  logic                           q_valid;
  logic [QW-1:0]                  q_data;
  logic                           q_pop;
  logic [ppve_pkg::VOL_BITS-1:0]  prism_volume;
  logic                           volume_saturated;
  logic                           incomplete;
  logic [CB-1:0]                  x_min;
  logic [CB-1:0]                  x_max;
  logic [CB-1:0]                  y_min;
  logic [CB-1:0]                  y_max;
  logic [ppve_pkg::ZMIN_BITS-1:0] z_min;
  logic [ppve_pkg::HD_BITS-1:0]   z_max;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_depth <= '0;
    end else if (cfg_valid) begin
      half_depth <= cfg_data;
    end
  end

  ppve_front #(
    .COORD_BITS   (COORD_BITS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_x       (s_axis_tdata[CB-1:0]),
    .in_y       (s_axis_tdata[2*CB-1:CB]),
    .in_last    (s_axis_tlast),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  ppve_queue #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .head_data (q_data),
    .not_empty (q_valid),
    .full      (queue_full)
  );

  ppve_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .half_depth       (half_depth),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .prism_volume     (prism_volume),
    .volume_saturated (volume_saturated),
    .incomplete       (incomplete),
    .x_min            (x_min),
    .x_max            (x_max),
    .y_min            (y_min),
    .y_max            (y_max),
    .z_min            (z_min),
    .z_max            (z_max)
  );

  // Pack result fields, lowest first
  assign m_axis_tdata = OUT_W'({z_max, z_min, y_max, y_min, x_max, x_min, prism_volume});
  assign m_axis_tuser[ppve_pkg::USER_SAT] = volume_saturated;
  assign m_axis_tuser[ppve_pkg::USER_INC] = incomplete;

endmodule

FILE: hw/rtl/ppve_front.sv
// ----------------------------------------------------------------------------
// ppve_front
// Accepts vertices, counts held vertices and classifies each transfer into a
// queue entry; drops vertices past the buffer limit.
// ----------------------------------------------------------------------------
module ppve_front #(
  parameter int COORD_BITS   = 20,
  parameter int MAX_VERTICES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic                  in_last,
  output logic                  push,
  output logic [2*COORD_BITS+ppve_pkg::KIND_BITS-1:0] push_data,
  input  logic                  queue_full
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     count_after;
  logic                 accept;
  logic                 held;
  ppve_pkg::ppve_kind_t kind;

  // Take a vertex whenever the queue has room
  assign in_ready    = !queue_full;
  assign accept      = in_valid && in_ready;
  assign held        = (count < CNT_W'(MAX_VERTICES));
  assign count_after = held ? count + CNT_W'(1) : count;

  // Classify the vertex
  always_comb begin
    kind.keep  = held;
    kind.first = held && (count == '0);
    kind.last  = in_last;
    kind.few   = (count_after < CNT_W'(3));
  end

  // Queue held vertices and every polygon close; drop the rest
  assign push      = accept && (held || in_last);
  assign push_data = {in_y, in_x, kind};

  // Count held vertices, restart after the closing vertex
  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = in_last ? '0 : count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

FILE: hw/rtl/ppve_queue.sv
// ----------------------------------------------------------------------------
// ppve_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module ppve_queue #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_data = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ppve_back.sv
// ----------------------------------------------------------------------------
// ppve_back
// Sequencer that carries out queue entries: shoelace accumulation, bounding
// box, closing term, volume multiply with saturation, and the result register.
// ----------------------------------------------------------------------------
module ppve_back #(
  parameter int COORD_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ppve_pkg::HD_BITS-1:0] half_depth,
  input  logic                  q_valid,
  input  logic [2*COORD_BITS+ppve_pkg::KIND_BITS-1:0] q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ppve_pkg::VOL_BITS-1:0]  prism_volume,
  output logic                  volume_saturated,
  output logic                  incomplete,
  output logic [COORD_BITS-1:0] x_min,
  output logic [COORD_BITS-1:0] x_max,
  output logic [COORD_BITS-1:0] y_min,
  output logic [COORD_BITS-1:0] y_max,
  output logic [ppve_pkg::ZMIN_BITS-1:0] z_min,
  output logic [ppve_pkg::HD_BITS-1:0]   z_max
);

  localparam int CB       = COORD_BITS;
  localparam int KB       = ppve_pkg::KIND_BITS;
  localparam int HB       = ppve_pkg::HD_BITS;
  localparam int SUM_BITS = 2 * CB + ppve_pkg::SUM_GUARD;
  localparam int LO_BITS  = (SUM_BITS + 1) / 2;
  localparam int HI_BITS  = SUM_BITS - LO_BITS;
  localparam int PROD_W   = SUM_BITS + HB;
  localparam int VB       = ppve_pkg::VOL_BITS;
  localparam int PW       = (PROD_W > VB + 1) ? PROD_W : VB + 1;

  ppve_pkg::ppve_state_t state;
  ppve_pkg::ppve_state_t state_next;

  ppve_pkg::ppve_kind_t  q_kind;
  ppve_pkg::ppve_kind_t  ent_kind;
  logic signed [CB-1:0]  ent_x;
  logic signed [CB-1:0]  ent_y;
  logic signed [CB-1:0]  first_x;
  logic signed [CB-1:0]  first_y;
  logic signed [CB-1:0]  prev_x;
  logic signed [CB-1:0]  prev_y;
  logic signed [CB-1:0]  run_x_min;
  logic signed [CB-1:0]  run_x_max;
  logic signed [CB-1:0]  run_y_min;
  logic signed [CB-1:0]  run_y_max;
  logic signed [2*CB-1:0] prod_p;
  logic signed [2*CB-1:0] prod_q;
  logic [2*CB:0]         diff;
  logic [SUM_BITS-1:0]   term;
  logic [SUM_BITS-1:0]   cross_sum;
  logic [SUM_BITS-1:0]   closed_sum;
  logic [SUM_BITS-1:0]   mag;
  logic [LO_BITS+HB-1:0] part_lo;
  logic [HI_BITS+HB-1:0] part_hi;
  logic [PW-1:0]         volume;
  logic                  over;
  logic                  fin_load;

  assign q_kind = ppve_pkg::ppve_kind_t'(q_data[KB-1:0]);

  // Cross term of the two registered products, sign-extended to the sum width
  assign diff       = {prod_p[2*CB-1], prod_p} - {prod_q[2*CB-1], prod_q};
  assign term       = {{(SUM_BITS-2*CB-1){diff[2*CB]}}, diff};
  assign closed_sum = cross_sum + term;
  assign over       = |volume[PW-1:VB];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ppve_pkg::B_IDLE: begin
        if (q_valid) begin
          state_next = q_kind.keep ? ppve_pkg::B_MUL : ppve_pkg::B_CLOSE;
        end
      end
      ppve_pkg::B_MUL: state_next = ppve_pkg::B_ACC;
      ppve_pkg::B_ACC: begin
        priority if (ent_kind.last) begin
          state_next = ppve_pkg::B_CLOSE;
        end else if (q_valid) begin
          state_next = q_kind.keep ? ppve_pkg::B_MUL : ppve_pkg::B_CLOSE;
        end else begin
          state_next = ppve_pkg::B_IDLE;
        end
      end
      ppve_pkg::B_CLOSE: state_next = ent_kind.few ? ppve_pkg::B_FIN : ppve_pkg::B_CSUM;
      ppve_pkg::B_CSUM:  state_next = ppve_pkg::B_VMUL;
      ppve_pkg::B_VMUL:  state_next = ppve_pkg::B_VSUM;
      ppve_pkg::B_VSUM:  state_next = ppve_pkg::B_FIN;
      ppve_pkg::B_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = ppve_pkg::B_IDLE;
        end
      end
      default: state_next = ppve_pkg::B_IDLE;
    endcase
  end

  // Sequencer outputs: queue pop and result load
  always_comb begin
    q_pop    = 1'b0;
    fin_load = 1'b0;
    unique case (state)
      ppve_pkg::B_IDLE: q_pop    = q_valid;
      ppve_pkg::B_ACC:  q_pop    = q_valid && !ent_kind.last;
      ppve_pkg::B_FIN:  fin_load = !out_valid || out_ready;
      default: begin
        q_pop    = 1'b0;
        fin_load = 1'b0;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppve_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_kind <= q_kind;
      ent_x    <= q_data[KB+CB-1:KB];
      ent_y    <= q_data[KB+2*CB-1:KB+CB];
    end
    unique case (state)
      ppve_pkg::B_MUL: begin
        prod_p <= prev_x * ent_y;
        prod_q <= ent_x * prev_y;
      end
      ppve_pkg::B_ACC: begin
        if (ent_kind.first) begin
          first_x   <= ent_x;
          first_y   <= ent_y;
          run_x_min <= ent_x;
          run_x_max <= ent_x;
          run_y_min <= ent_y;
          run_y_max <= ent_y;
          cross_sum <= '0;
        end else begin
          cross_sum <= closed_sum;
          if (ent_x < run_x_min) run_x_min <= ent_x;
          if (ent_x > run_x_max) run_x_max <= ent_x;
          if (ent_y < run_y_min) run_y_min <= ent_y;
          if (ent_y > run_y_max) run_y_max <= ent_y;
        end
        prev_x <= ent_x;
        prev_y <= ent_y;
      end
      ppve_pkg::B_CLOSE: begin
        prod_p <= prev_x * first_y;
        prod_q <= first_x * prev_y;
      end
      ppve_pkg::B_CSUM: begin
        mag <= closed_sum[SUM_BITS-1] ? (~closed_sum + SUM_BITS'(1)) : closed_sum;
      end
      ppve_pkg::B_VMUL: begin
        part_lo <= mag[LO_BITS-1:0] * half_depth;
        part_hi <= mag[SUM_BITS-1:LO_BITS] * half_depth;
      end
      ppve_pkg::B_VSUM: begin
        volume <= PW'({part_hi, {LO_BITS{1'b0}}}) + PW'(part_lo);
      end
      default: begin
      end
    endcase
    // Load the result register
    if (fin_load) begin
      if (ent_kind.few) begin
        prism_volume     <= '0;
        volume_saturated <= 1'b0;
        incomplete       <= 1'b1;
        x_min            <= '0;
        x_max            <= '0;
        y_min            <= '0;
        y_max            <= '0;
        z_min            <= '0;
        z_max            <= '0;
      end else begin
        prism_volume     <= over ? {VB{1'b1}} : volume[VB-1:0];
        volume_saturated <= over;
        incomplete       <= 1'b0;
        x_min            <= run_x_min;
        x_max            <= run_x_max;
        y_min            <= run_y_min;
        y_max            <= run_y_max;
        z_min            <= ppve_pkg::ZMIN_BITS'(0) - ppve_pkg::ZMIN_BITS'(half_depth);
        z_max            <= half_depth;
      end
    end
  end

  // Result valid: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/ppve_checker.sv
// ----------------------------------------------------------------------------
// ppve_checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ppve_checker #(
  parameter int COORD_BITS = 20
) (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((ppve_pkg::VOL_BITS+4*COORD_BITS+ppve_pkg::ZMIN_BITS
                 +ppve_pkg::HD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic [ppve_pkg::USER_BITS-1:0] m_axis_tuser
);

  localparam int VB    = ppve_pkg::VOL_BITS;
  localparam int CB    = COORD_BITS;
  localparam int ZB    = ppve_pkg::ZMIN_BITS;
  localparam int OX    = VB;
  localparam int OY    = VB + 2 * CB;
  localparam int OZ    = VB + 4 * CB;

  logic              sat;
  logic              inc;
  logic signed [CB-1:0] xlo;
  logic signed [CB-1:0] xhi;
  logic signed [CB-1:0] ylo;
  logic signed [CB-1:0] yhi;
  logic [ZB-1:0]     zlo;
  logic [ZB-1:0]     zhi;

  assign sat = m_axis_tuser[ppve_pkg::USER_SAT];
  assign inc = m_axis_tuser[ppve_pkg::USER_INC];
  assign xlo = m_axis_tdata[OX+CB-1:OX];
  assign xhi = m_axis_tdata[OX+2*CB-1:OX+CB];
  assign ylo = m_axis_tdata[OY+CB-1:OY];
  assign yhi = m_axis_tdata[OY+2*CB-1:OY+CB];
  assign zlo = m_axis_tdata[OZ+ZB-1:OZ];
  assign zhi = ZB'(m_axis_tdata[OZ+ZB+ppve_pkg::HD_BITS-1:OZ+ZB]);

  // Hold a pending result until transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // Incomplete polygon carries an all-zero result
  a_incomplete: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && inc |-> m_axis_tdata == '0 && !sat)
    else $error("incomplete result carries data");

  // Saturation clamps the volume to all ones
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && sat |-> &m_axis_tdata[VB-1:0])
    else $error("saturated volume not clamped");

  // Bounding box is ordered and z is symmetric
  a_box: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !inc |-> xlo <= xhi && ylo <= yhi && (zlo + zhi) == '0)
    else $error("bounding box inconsistent");

endmodule

bind polygon_prism_volume_extent ppve_checker #(
  .COORD_BITS (COORD_BITS)
) u_ppve_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
